// ===== sv/swmf_pkg.sv =====
package swmf_pkg;

  // Fixed field widths of the sample stream and the window register.
  localparam int DATA_W = 32;
  localparam int WS_W   = 7;

  localparam logic [WS_W-1:0] WS_RESET = 7'd3;

  typedef logic signed [DATA_W-1:0] sample_t;
  typedef logic [WS_W-1:0]          win_size_t;

  // Which candidate the store is read at.
  typedef enum logic {
    RD_HEAD,
    RD_TAIL
  } rd_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    accept;
    rd_sel_e rd_sel;
    logic    head_drop;
    logic    tail_pop;
    logic    append;
    logic    out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic count_zero;
    logic expired;
    logic smaller;
    logic result_due;
    logic out_free;
  } sts_t;

endpackage

// ===== sv/swmf_ram.sv =====
module swmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/swmf_ctrl.sv =====
module swmf_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  swmf_pkg::sts_t sts_i,
  output swmf_pkg::cmd_t cmd_o
);

  import swmf_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_HEAD_RD  = 3'd1;
  localparam logic [2:0] S_HEAD_CHK = 3'd2;
  localparam logic [2:0] S_TAIL_RD  = 3'd3;
  localparam logic [2:0] S_TAIL_CHK = 3'd4;
  localparam logic [2:0] S_APPEND   = 3'd5;
  localparam logic [2:0] S_OUT_RD   = 3'd6;
  localparam logic [2:0] S_OUT      = 3'd7;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.rd_sel = RD_HEAD;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_HEAD_RD;
        end
      end
      S_HEAD_RD: begin
        state_d = sts_i.count_zero ? S_APPEND : S_HEAD_CHK;
      end
      S_HEAD_CHK: begin
        if (sts_i.expired) begin
          cmd_o.head_drop = 1'b1;
          state_d         = S_HEAD_RD;
        end else begin
          state_d = S_TAIL_RD;
        end
      end
      S_TAIL_RD: begin
        cmd_o.rd_sel = RD_TAIL;
        state_d      = sts_i.count_zero ? S_APPEND : S_TAIL_CHK;
      end
      S_TAIL_CHK: begin
        if (sts_i.smaller) begin
          cmd_o.tail_pop = 1'b1;
          state_d        = S_TAIL_RD;
        end else begin
          state_d = S_APPEND;
        end
      end
      S_APPEND: begin
        cmd_o.append = 1'b1;
        state_d      = sts_i.result_due ? S_OUT_RD : S_IDLE;
      end
      S_OUT_RD: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // A head drop must only follow a head read that actually saw a candidate.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.head_drop |-> $past(state_q) == S_HEAD_RD)
    else $error("head drop without a preceding head read");

  // The output register is loaded only when it is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> sts_i.out_free)
    else $error("result loaded over a pending beat");

  // An accepted sample starts the head scan.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> state_q == S_HEAD_RD)
    else $error("accept did not start the head scan");

endmodule

// ===== sv/swmf_dp.sv =====
module swmf_dp #(
  parameter int WINDOW_MAX = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                ws_we_i,
  input  swmf_pkg::win_size_t ws_i,
  input  swmf_pkg::sample_t   sample_i,
  input  logic                first_of_stream_i,
  input  swmf_pkg::cmd_t      cmd_i,
  output swmf_pkg::sts_t      sts_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output swmf_pkg::sample_t   window_max_o
);

  import swmf_pkg::*;

  localparam int IW  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CW  = $clog2(WINDOW_MAX + 1);
  localparam int PW  = $clog2(2 * WINDOW_MAX);
  localparam int SW  = CW + 1;
  localparam int EW  = (CW > WS_W) ? CW : WS_W;
  localparam int RW  = PW + DATA_W;
  localparam int POS_MOD = 2 * WINDOW_MAX;

  win_size_t       ws_q;
  sample_t         x_q;
  logic [IW-1:0]   head_q, head_d;
  logic [CW-1:0]   count_q, count_d;
  logic [PW-1:0]   pos_q, pos_d;
  logic [CW-1:0]   fill_q, fill_d;
  logic            out_valid_q;
  sample_t         window_max_q;

  // Effective window, clamped to 1..WINDOW_MAX.
  logic [EW-1:0] ws_ext;
  logic [CW-1:0] win;

  always_comb begin
    ws_ext = EW'(ws_q);
    if (ws_ext == '0) begin
      win = CW'(1);
    end else if (ws_ext > EW'(WINDOW_MAX)) begin
      win = CW'(WINDOW_MAX);
    end else begin
      win = CW'(ws_ext);
    end
  end

  // Ring addresses of the tail candidate and of the next free slot.
  logic [SW-1:0] tail_sum, free_sum;
  logic [IW-1:0] tail_idx, free_idx, head_inc;
  logic          full;

  always_comb begin
    tail_sum = SW'(head_q) + SW'(count_q) - SW'(1);
    free_sum = SW'(head_q) + SW'(count_q);
    tail_idx = (tail_sum >= SW'(WINDOW_MAX)) ? IW'(tail_sum - SW'(WINDOW_MAX)) : IW'(tail_sum);
    free_idx = (free_sum >= SW'(WINDOW_MAX)) ? IW'(free_sum - SW'(WINDOW_MAX)) : IW'(free_sum);
    head_inc = (head_q == IW'(WINDOW_MAX - 1)) ? '0 : head_q + IW'(1);
    full     = (count_q == CW'(WINDOW_MAX));
  end

  // Candidate store: position above value.
  logic [IW-1:0] raddr, waddr;
  logic [RW-1:0] rdata, wdata;
  logic [PW-1:0] rd_pos;
  sample_t       rd_value;

  assign raddr = (cmd_i.rd_sel == RD_TAIL) ? tail_idx : head_q;
  assign waddr = full ? head_q : free_idx;
  assign wdata = {pos_q, x_q};

  swmf_ram #(
    .WIDTH (RW),
    .DEPTH (WINDOW_MAX)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.append),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign rd_pos   = rdata[RW-1:DATA_W];
  assign rd_value = sample_t'(rdata[DATA_W-1:0]);

  // Age of the candidate just read, modulo the position range.
  logic [PW-1:0] age;
  always_comb begin
    if (pos_q >= rd_pos) begin
      age = pos_q - rd_pos;
    end else begin
      age = PW'(POS_MOD - 1) - rd_pos + pos_q + PW'(1);
    end
  end

  // Fill count after this sample, clamped to the current window.
  logic [CW-1:0] fill_clamp, fill_next;
  always_comb begin
    fill_clamp = (fill_q > win) ? win : fill_q;
    fill_next  = (fill_clamp < win) ? fill_clamp + CW'(1) : fill_clamp;
  end

  assign sts_o.count_zero = (count_q == '0);
  assign sts_o.expired    = (age >= PW'(win));
  assign sts_o.smaller    = (rd_value < x_q);
  assign sts_o.result_due = (fill_next == win);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    pos_d   = pos_q;
    fill_d  = fill_q;
    if (cmd_i.accept && first_of_stream_i) begin
      head_d  = '0;
      count_d = '0;
      pos_d   = '0;
      fill_d  = '0;
    end
    if (cmd_i.head_drop) begin
      head_d  = head_inc;
      count_d = count_q - CW'(1);
    end
    if (cmd_i.tail_pop) begin
      count_d = count_q - CW'(1);
    end
    if (cmd_i.append) begin
      // A full store drops its head to make room; the count stays.
      if (full) begin
        head_d = head_inc;
      end else begin
        count_d = count_q + CW'(1);
      end
      pos_d  = (pos_q == PW'(POS_MOD - 1)) ? '0 : pos_q + PW'(1);
      fill_d = fill_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ws_q        <= WS_RESET;
      head_q      <= '0;
      count_q     <= '0;
      pos_q       <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ws_we_i) begin
        ws_q <= ws_i;
      end
      head_q  <= head_d;
      count_q <= count_d;
      pos_q   <= pos_d;
      fill_q  <= fill_d;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      x_q <= sample_i;
    end
    if (cmd_i.out_load) begin
      window_max_q <= rd_value;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign window_max_o = window_max_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(WINDOW_MAX))
    else $error("candidate count beyond store depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.head_drop || cmd_i.tail_pop) |-> count_q != '0)
    else $error("candidate dropped from an empty store");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.append |=> count_q != '0)
    else $error("store empty right after an append");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PW'(POS_MOD - 1))
    else $error("position counter out of range");

endmodule

// ===== sv/sliding_window_max_filter_core.sv =====
// Channel  Direction  Handshake                  Beat contents
// in       input      in_valid_i / in_ready_o    sample_i, first_of_stream_i
// out      output     out_valid_o / out_ready_i  window_max_o
// cfg      input      window_size_we_i           window_size_i (no wait, no read-back)
//
// Each sample drops h expired candidates at the head and t candidates smaller than
// itself at the tail, examining one candidate at a time through the single read port
// of the candidate RAM, whose read is registered. A new sample is accepted only once
// the previous one has been appended and its result, if due, loaded.
// Reset is asynchronous and active low; it empties the store by clearing its
// count, and the RAM contents are never cleared. A result that is not yet taken
// waits in the output register while the next beat is accepted; the controller
// stalls only when a further result is due and that register is still full.

module sliding_window_max_filter_core #(
  parameter int WINDOW_MAX = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                window_size_we_i,
  input  swmf_pkg::win_size_t window_size_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  swmf_pkg::sample_t   sample_i,
  input  logic                first_of_stream_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output swmf_pkg::sample_t   window_max_o
);

  import swmf_pkg::*;

  // The controller walks the candidate store one read at a time: first over
  // the head while candidates are too old for the window, then over the tail
  // while candidates are strictly smaller than the new sample. Equal values
  // are kept, so the oldest of several equal maxima stays at the head.
  cmd_t cmd;
  sts_t sts;

  swmf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // The datapath holds the window register, ring pointers, position and fill
  // counters, the candidate RAM and the output register. Once the stream has
  // delivered a full window, every sample loads the head value as its result.
  swmf_dp #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .ws_we_i           (window_size_we_i),
    .ws_i              (window_size_i),
    .sample_i          (sample_i),
    .first_of_stream_i (first_of_stream_i),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .out_ready_i       (out_ready_i),
    .out_valid_o       (out_valid_o),
    .window_max_o      (window_max_o)
  );

endmodule
